// ===== design/voronoi_nearest_seed_labeler_defines.svh =====
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_labeler_defines.svh
// Assertion macros shared by the labeler RTL.
// ----------------------------------------------------------------------------
`ifndef VORONOI_NEAREST_SEED_LABELER_DEFINES_SVH
`define VORONOI_NEAREST_SEED_LABELER_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define VNSL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define VNSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/vnsl_pkg.sv =====
// ----------------------------------------------------------------------------
// vnsl_pkg
// Types, constants and helpers for the Voronoi nearest-seed labeler.
// ----------------------------------------------------------------------------
package vnsl_pkg;

   // default parameter values
   localparam int DEF_MAX_SEEDS  = 256;
   localparam int DEF_COORD_BITS = 12;

   // register reset values
   localparam int SEED_COUNT_RESET   = 256;
   localparam int FRAME_WIDTH_RESET  = 1024;
   localparam int FRAME_HEIGHT_RESET = 768;

   // field widths
   localparam int PIX_BITS      = 12;
   localparam int SEED_BITS     = 16;
   localparam int FRAC_BITS     = 4;
   localparam int FRAME_BITS    = 13;
   localparam int COUNT_BITS    = 9;
   localparam int CSR_DATA_BITS = 13;
   localparam int DIST_BITS     = 2 * SEED_BITS + 1;

   // gray step dividend
   localparam int             GRAY_BITS = 9;
   localparam int             GRAY_SPAN = 256;
   localparam logic [8:0]     GRAY_SPAN_VEC = 9'd256;
   localparam logic [3:0]     GRAY_TOP_BIT  = 4'd8;

   // register indexes
   typedef enum logic [1:0] {
      CSR_SEED_COUNT   = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } vnsl_csr_type;

   // item moving down the cell chain; data is {y, x} for both kinds
   typedef struct packed {
      logic                   query;
      logic [7:0]             slot;
      logic [2*SEED_BITS-1:0] data;
      logic                   outside;
      logic [DIST_BITS-1:0]   best_dist;
   } vnsl_item_type;

   // seed count as used by the search: zero acts as one, saturates at max
   function automatic int vnsl_clamp_count(input int value, input int max_seeds);
      int n;
      n = value;
      if (n == 0) n = 1;
      if (n > max_seeds) n = max_seeds;
      return n;
   endfunction

endpackage

// ===== design/vnsl_req_if.sv =====
// ----------------------------------------------------------------------------
// vnsl_req_if
// Request channel: seed loads and pixel queries.
// ----------------------------------------------------------------------------
interface vnsl_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  seed_slot;
   logic [15:0] seed_x;
   logic [15:0] seed_y;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;

   modport source (output valid, action, seed_slot, seed_x, seed_y, pixel_x, pixel_y,
                   input ready);
   modport sink   (input valid, action, seed_slot, seed_x, seed_y, pixel_x, pixel_y,
                   output ready);
endinterface

// ===== design/vnsl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vnsl_rsp_if
// Response channel: one label per pixel query.
// ----------------------------------------------------------------------------
interface vnsl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] nearest_seed;
   logic [7:0] gray_level;
   logic       outside_frame;

   modport source (output valid, nearest_seed, gray_level, outside_frame, input ready);
   modport sink   (input valid, nearest_seed, gray_level, outside_frame, output ready);
endinterface

// ===== design/vnsl_cell.sv =====
// ----------------------------------------------------------------------------
// vnsl_cell
// One seed of the chain: holds the seed, squares the offsets, keeps the best.
// ----------------------------------------------------------------------------
module vnsl_cell
   import vnsl_pkg::*;
#(
   parameter int MAX_SEEDS = DEF_MAX_SEEDS,
   parameter int INDEX     = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [$clog2(MAX_SEEDS+1)-1:0]     active_count,
   input  logic                               valid_i,
   input  vnsl_item_type                      item_i,
   input  logic [$clog2(MAX_SEEDS)-1:0]       best_idx_i,
   output logic                               valid_o,
   output vnsl_item_type                      item_o,
   output logic [$clog2(MAX_SEEDS)-1:0]       best_idx_o
);

   localparam int IDX_W = $clog2(MAX_SEEDS);

   logic [2*SEED_BITS-1:0] seed_ff;
   logic                   load_hit;

   logic                   s1_valid_ff;
   vnsl_item_type          s1_item_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic [2*SEED_BITS-1:0] sqx_ff, sqx_in;
   logic [2*SEED_BITS-1:0] sqy_ff, sqy_in;
   logic [SEED_BITS-1:0]   dx, dy;

   logic                   s2_valid_ff;
   vnsl_item_type          s2_item_ff, s2_item_in;
   logic [IDX_W-1:0]       s2_idx_ff, s2_idx_in;
   logic [DIST_BITS-1:0]   dist_sum;
   logic                   cell_active;
   logic                   take;

   // seed write as a load transfer passes this cell
   assign load_hit = valid_i && !item_i.query && (32'(item_i.slot) == 32'(INDEX));

   always_ff @(posedge clock) begin
      if (advance && load_hit) begin
         seed_ff <= item_i.data;
      end
   end

   // stage 1: absolute offsets and their squares
   always_comb begin
      dx = (item_i.data[15:0] >= seed_ff[15:0]) ? item_i.data[15:0] - seed_ff[15:0]
                                                : seed_ff[15:0] - item_i.data[15:0];
      dy = (item_i.data[31:16] >= seed_ff[31:16]) ? item_i.data[31:16] - seed_ff[31:16]
                                                  : seed_ff[31:16] - item_i.data[31:16];
      sqx_in = dx * dx;
      sqy_in = dy * dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= item_i;
         s1_idx_ff  <= best_idx_i;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
      end
   end

   // stage 2: distance sum and compare; first seed always wins, ties keep earlier
   always_comb begin
      dist_sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      cell_active = 32'(INDEX) < 32'(active_count);
      take        = cell_active && ((INDEX == 0) || (dist_sum < s1_item_ff.best_dist));
      s2_item_in  = s1_item_ff;
      s2_idx_in   = s1_idx_ff;
      if (take) begin
         s2_item_in.best_dist = dist_sum;
         s2_idx_in            = IDX_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_item_ff <= s2_item_in;
         s2_idx_ff  <= s2_idx_in;
      end
   end

   assign valid_o    = s2_valid_ff;
   assign item_o     = s2_item_ff;
   assign best_idx_o = s2_idx_ff;

endmodule

// ===== design/vnsl_gray_div.sv =====
// ----------------------------------------------------------------------------
// vnsl_gray_div
// Restoring divider, one quotient bit a cycle: gray step = 256 / seed count.
// ----------------------------------------------------------------------------
module vnsl_gray_div
   import vnsl_pkg::*;
#(
   parameter int MAX_SEEDS = DEF_MAX_SEEDS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [$clog2(MAX_SEEDS+1)-1:0] count,
   output logic                           busy,
   output logic [GRAY_BITS-1:0]           step
);

   localparam int CNT_W     = $clog2(MAX_SEEDS+1);
   localparam int RST_COUNT = vnsl_clamp_count(SEED_COUNT_RESET, MAX_SEEDS);
   localparam int RST_STEP  = GRAY_SPAN / RST_COUNT;

   logic                 busy_ff;
   logic [3:0]           bit_ff;
   logic [CNT_W-1:0]     den_ff;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [GRAY_BITS-1:0] quo_ff, quo_in;
   logic [GRAY_BITS-1:0] step_ff;
   logic [CNT_W:0]       trial;
   logic                 fits;

   // one restoring step
   always_comb begin
      trial  = {rem_ff, GRAY_SPAN_VEC[bit_ff]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
      quo_in = {quo_ff[GRAY_BITS-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= GRAY_BITS'(RST_STEP);
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && (bit_ff == '0)) begin
         busy_ff <= 1'b0;
         step_ff <= quo_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= count;
         rem_ff <= '0;
         quo_ff <= '0;
         bit_ff <= GRAY_TOP_BIT;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         bit_ff <= bit_ff - 4'd1;
      end
   end

   assign busy = busy_ff;
   assign step = step_ff;

endmodule

// ===== design/voronoi_nearest_seed_labeler.sv =====
// A query result is registered in every cell of the chain and then in the output register.
// Throughput: one item per cycle, seed loads and queries alike, while the output
//    is not stalled; one cell per seed, two register stages per cell, the whole chain advancing together.
// A seed_count write starts the gray-step divider: no request is taken while it is
//    busy, one quotient bit per cycle.
// Reset: registers to 256 / 1024 / 768, chain emptied; seeds undefined.
`include "voronoi_nearest_seed_labeler_defines.svh"
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_labeler
// Nearest-seed Voronoi labeling through a chain of seed cells.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_labeler
   import vnsl_pkg::*;
#(
   parameter int MAX_SEEDS  = DEF_MAX_SEEDS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   vnsl_req_if.sink                 req_if,
   vnsl_rsp_if.source               rsp_if,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int IDX_W     = $clog2(MAX_SEEDS);
   localparam int CNT_W     = $clog2(MAX_SEEDS+1);
   localparam int RST_COUNT = vnsl_clamp_count(SEED_COUNT_RESET, MAX_SEEDS);
   localparam logic [PIX_BITS-1:0] PIX_MASK =
      (COORD_BITS >= PIX_BITS) ? {PIX_BITS{1'b1}} : PIX_BITS'((1 << COORD_BITS) - 1);

   // configuration
   logic [CNT_W-1:0]      count_ff;
   logic [FRAME_BITS-1:0] width_ff;
   logic [FRAME_BITS-1:0] height_ff;
   logic                  div_start;
   logic                  div_busy;
   logic [GRAY_BITS-1:0]  gray_step;
   logic [CNT_W-1:0]      count_in;

   assign count_in  = CNT_W'(vnsl_clamp_count(int'(csr_data[COUNT_BITS-1:0]), MAX_SEEDS));
   assign div_start = csr_we && (csr_index == CSR_SEED_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CNT_W'(RST_COUNT);
         width_ff  <= FRAME_BITS'(FRAME_WIDTH_RESET);
         height_ff <= FRAME_BITS'(FRAME_HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEED_COUNT:   count_ff  <= count_in;
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   vnsl_gray_div #(
      .MAX_SEEDS (MAX_SEEDS)
   ) u_gray_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .count (count_in),
      .busy  (div_busy),
      .step  (gray_step)
   );

   // chain flow: everything moves unless a result is stuck at the output
   logic rsp_valid_ff;
   logic advance;
   logic req_xfer;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance && !div_busy;
   assign req_xfer     = req_if.valid && req_if.ready;

   // chain entry
   logic                 chain_valid [0:MAX_SEEDS];
   vnsl_item_type        chain_item  [0:MAX_SEEDS];
   logic [IDX_W-1:0]     chain_idx   [0:MAX_SEEDS];
   logic [PIX_BITS-1:0]  px, py;

   always_comb begin
      px = req_if.pixel_x & PIX_MASK;
      py = req_if.pixel_y & PIX_MASK;
      chain_valid[0]          = req_xfer;
      chain_item[0].query     = req_if.action;
      chain_item[0].slot      = req_if.seed_slot;
      chain_item[0].data      = req_if.action ?
                                {py, {FRAC_BITS{1'b0}}, px, {FRAC_BITS{1'b0}}} :
                                {req_if.seed_y, req_if.seed_x};
      chain_item[0].outside   = ({1'b0, px} >= width_ff) || ({1'b0, py} >= height_ff);
      chain_item[0].best_dist = '0;
      chain_idx[0]            = '0;
   end

   // one cell per seed
   for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
      vnsl_cell #(
         .MAX_SEEDS (MAX_SEEDS),
         .INDEX     (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .active_count (count_ff),
         .valid_i      (chain_valid[g]),
         .item_i       (chain_item[g]),
         .best_idx_i   (chain_idx[g]),
         .valid_o      (chain_valid[g+1]),
         .item_o       (chain_item[g+1]),
         .best_idx_o   (chain_idx[g+1])
      );
   end

   // output register; loads drop out here
   logic [7:0]  label_in;
   logic [15:0] gray_prod;
   logic [7:0]  label_ff;
   logic [7:0]  gray_ff;
   logic        outside_ff;

   always_comb begin
      label_in  = 8'(32'(chain_idx[MAX_SEEDS]));
      gray_prod = label_in * gray_step[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[MAX_SEEDS] && chain_item[MAX_SEEDS].query;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         label_ff   <= label_in;
         gray_ff    <= gray_prod[7:0];
         outside_ff <= chain_item[MAX_SEEDS].outside;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.nearest_seed  = label_ff;
   assign rsp_if.gray_level    = gray_ff;
   assign rsp_if.outside_frame = outside_ff;

   // checks
   `VNSL_ASSERT_NEXT(a_div_starts, div_start, div_busy, "gray divider did not start")
   `VNSL_ASSERT_NOW(a_stall_blocks, rsp_valid_ff && !rsp_if.ready, !req_if.ready, "request taken while output stalled")
   `VNSL_ASSERT_NOW(a_single_seed, rsp_valid_ff && (count_ff == CNT_W'(1)), rsp_if.nearest_seed == 8'd0, "single seed search gave nonzero label")

endmodule
